>>> hw/rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Types and constants shared by the pixel stream decoder files.
// ----------------------------------------------------------------------------
package tpd_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SELECT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd3;

    // depth codes; the unused fourth code behaves as 32 bpp
    localparam logic [1:0] DEPTH_16 = 2'd0;
    localparam logic [1:0] DEPTH_24 = 2'd1;
    localparam logic [1:0] DEPTH_32 = 2'd2;

    // index of the last byte of a pixel, per depth
    localparam logic [1:0] LAST_BYTE_16 = 2'd1;
    localparam logic [1:0] LAST_BYTE_24 = 2'd2;
    localparam logic [1:0] LAST_BYTE_32 = 2'd3;

    // run-length header split: below this is a raw packet
    localparam logic [7:0] RLE_REPEAT_FLAG = 8'd128;

    typedef struct packed {
        logic [7:0] data_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
    } pixel_beat_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          value;
    } cfg_beat_t;

endpackage

>>> hw/rtl/tpd_stream_if.sv
// ----------------------------------------------------------------------------
// tpd_stream_if
// Valid/ready channel carrying one payload struct per beat.
// ----------------------------------------------------------------------------
interface tpd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/tga_pixel_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top
// Decodes raw or run-length image pixel bytes into RGBA pixels with a
// repeat count per beat.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                     | accepted when
//  ---------+-----+---------------------------------------------+--------------
//  stream   | in  | data_byte                                   | valid & ready
//  pixels   | out | red green blue alpha repeat_count last_pixel| valid & ready
//  cfg      | in  | index, value (write)                        | valid & ready
//
//  One byte per cycle while stream.ready is high; each byte is decoded by
//  a single logic stage into the output register, so a result shows the
//  cycle after its last byte. The output register is the only buffer:
//  stream.ready drops only while a result sits unaccepted on pixels.
//  cfg.ready is always high. Reset (rst_n low, async) clears control state
//  and loads default config. A cfg write to indexes 0-3 restarts the image;
//  the image size product is computed by one 16x16 multiply on the write.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_top (
    input  logic         clk,
    input  logic         rst_n,
    tpd_stream_if.sink   stream,
    tpd_stream_if.source pixels,
    tpd_stream_if.sink   cfg
);

    // configuration
    logic        rle_mode_reg;
    logic [1:0]  depth_select_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [31:0] total_reg;

    // stream state; remaining counts down from width*height
    logic [31:0] remaining_reg,  remaining_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_is_repeat_reg, packet_is_repeat_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [7:0]  pixel_bytes_reg [3];

    // output register
    logic                 out_valid_reg, out_valid_next;
    tpd_pkg::pixel_beat_t out_beat_reg, out_beat_next;

    logic        in_fire;
    logic        cfg_fire;
    logic        cfg_hit;
    logic [15:0] width_new;
    logic [15:0] height_new;
    logic [31:0] total_new;

    logic        rle;
    logic [1:0]  last_byte;
    logic [7:0]  b;
    logic        pixel_done;
    logic        is_header;
    logic [7:0]  want;
    logic        hits_end;
    logic [7:0]  count;
    logic [15:0] word16;

    assign stream.ready  = !out_valid_reg || pixels.ready;
    assign cfg.ready     = 1'b1;
    assign pixels.valid  = out_valid_reg;
    assign pixels.payload = out_beat_reg;

    assign in_fire  = stream.valid && stream.ready;
    assign cfg_fire = cfg.valid;
    assign cfg_hit  = cfg_fire && (cfg.payload.index == tpd_pkg::REG_RLE_MODE
                                || cfg.payload.index == tpd_pkg::REG_DEPTH_SELECT
                                || cfg.payload.index == tpd_pkg::REG_IMAGE_WIDTH
                                || cfg.payload.index == tpd_pkg::REG_IMAGE_HEIGHT);

    // size after this write; zero dimensions count as one
    always_comb
    begin
        width_new  = image_width_reg;
        height_new = image_height_reg;
        if (cfg.payload.index == tpd_pkg::REG_IMAGE_WIDTH)
        begin
            width_new = cfg.payload.value;
        end
        if (cfg.payload.index == tpd_pkg::REG_IMAGE_HEIGHT)
        begin
            height_new = cfg.payload.value;
        end
        if (width_new == 16'd0)
        begin
            width_new = 16'd1;
        end
        if (height_new == 16'd0)
        begin
            height_new = 16'd1;
        end
        total_new = 32'(width_new) * 32'(height_new);
    end

    always_comb
    begin
        unique case (depth_select_reg)
            tpd_pkg::DEPTH_16: last_byte = tpd_pkg::LAST_BYTE_16;
            tpd_pkg::DEPTH_24: last_byte = tpd_pkg::LAST_BYTE_24;
            default:           last_byte = tpd_pkg::LAST_BYTE_32;
        endcase
    end

    assign rle        = rle_mode_reg && (depth_select_reg != tpd_pkg::DEPTH_16);
    assign b          = stream.payload.data_byte;
    assign is_header  = rle && (packet_left_reg == 8'd0);
    assign pixel_done = !is_header && (byte_in_pixel_reg == last_byte);
    assign word16     = {b, pixel_bytes_reg[0]};

    // repeat packets clip to what is left of the image
    assign want     = (rle && packet_is_repeat_reg) ? packet_left_reg : 8'd1;
    assign hits_end = remaining_reg <= 32'(want);
    assign count    = hits_end ? remaining_reg[7:0] : want;

    always_comb
    begin
        remaining_next        = remaining_reg;
        packet_left_next      = packet_left_reg;
        packet_is_repeat_next = packet_is_repeat_reg;
        byte_in_pixel_next    = byte_in_pixel_reg;
        out_valid_next        = out_valid_reg && !pixels.ready;
        out_beat_next         = out_beat_reg;

        if (in_fire)
        begin
            if (is_header)
            begin
                packet_is_repeat_next = b >= tpd_pkg::RLE_REPEAT_FLAG;
                packet_left_next      = packet_is_repeat_next
                                      ? b - (tpd_pkg::RLE_REPEAT_FLAG - 8'd1)
                                      : b + 8'd1;
            end
            else if (!pixel_done)
            begin
                byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
            end
            else
            begin
                byte_in_pixel_next = 2'd0;
                out_valid_next     = 1'b1;

                unique case (depth_select_reg)
                    tpd_pkg::DEPTH_16:
                    begin
                        out_beat_next.red   = {word16[14:10], 3'b000};
                        out_beat_next.green = {word16[9:5], 3'b000};
                        out_beat_next.blue  = {word16[4:0], 3'b000};
                        out_beat_next.alpha = 8'd0;
                    end
                    tpd_pkg::DEPTH_24:
                    begin
                        out_beat_next.red   = b;
                        out_beat_next.green = pixel_bytes_reg[1];
                        out_beat_next.blue  = pixel_bytes_reg[0];
                        out_beat_next.alpha = 8'd0;
                    end
                    default:
                    begin
                        out_beat_next.red   = pixel_bytes_reg[2];
                        out_beat_next.green = pixel_bytes_reg[1];
                        out_beat_next.blue  = pixel_bytes_reg[0];
                        out_beat_next.alpha = b;
                    end
                endcase
                out_beat_next.repeat_count = count;
                out_beat_next.last_pixel   = hits_end;

                if (rle && packet_is_repeat_reg)
                begin
                    packet_left_next = 8'd0;
                end
                else if (rle)
                begin
                    packet_left_next = packet_left_reg - 8'd1;
                end

                if (hits_end)
                begin
                    // image complete: start over for the next one
                    remaining_next        = total_reg;
                    packet_left_next      = 8'd0;
                    packet_is_repeat_next = 1'b0;
                end
                else
                begin
                    remaining_next = remaining_reg - 32'(count);
                end
            end
        end

        if (cfg_hit)
        begin
            remaining_next        = total_new;
            packet_left_next      = 8'd0;
            packet_is_repeat_next = 1'b0;
            byte_in_pixel_next    = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg         <= 1'b0;
            depth_select_reg     <= tpd_pkg::DEPTH_24;
            image_width_reg      <= 16'd1;
            image_height_reg     <= 16'd1;
            total_reg            <= 32'd1;
            remaining_reg        <= 32'd1;
            packet_left_reg      <= 8'd0;
            packet_is_repeat_reg <= 1'b0;
            byte_in_pixel_reg    <= 2'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg.payload.index)
                    tpd_pkg::REG_RLE_MODE:     rle_mode_reg     <= cfg.payload.value[0];
                    tpd_pkg::REG_DEPTH_SELECT: depth_select_reg <= cfg.payload.value[1:0];
                    tpd_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg.payload.value;
                    tpd_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg.payload.value;
                    default: ;
                endcase
            end
            if (cfg_hit)
            begin
                total_reg <= total_new;
            end
            remaining_reg        <= remaining_next;
            packet_left_reg      <= packet_left_next;
            packet_is_repeat_reg <= packet_is_repeat_next;
            byte_in_pixel_reg    <= byte_in_pixel_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
        if (in_fire && !is_header && !pixel_done && byte_in_pixel_reg != tpd_pkg::LAST_BYTE_32)
        begin
            pixel_bytes_reg[byte_in_pixel_reg] <= b;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_remaining_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg != 32'd0)
        else $error("remaining pixel count reached zero");

    a_remaining_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= total_reg)
        else $error("remaining pixel count exceeds image size");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid |-> pixels.payload.repeat_count != 8'd0)
        else $error("pixel beat with zero repeat count");

    a_byte_index: assert property (@(posedge clk) disable iff (!rst_n)
        byte_in_pixel_reg <= last_byte)
        else $error("byte index past end of pixel");

    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pixel_done && hits_end && !cfg_fire)
        |=> (remaining_reg == total_reg && packet_left_reg == 8'd0))
        else $error("stream state not restarted after last pixel");

endmodule

>>> tb/tpd_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpd_pixel_checker
// Watches the byte, pixel and config channels of the pixel stream decoder,
// decodes every accepted byte on its own and compares each pixel beat with
// the oldest pixel it predicted.
// ----------------------------------------------------------------------------
module tpd_pixel_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  stream_valid,
    input  logic                  stream_ready,
    input  tpd_pkg::byte_beat_t   stream_payload,
    input  logic                  pixels_valid,
    input  logic                  pixels_ready,
    input  tpd_pkg::pixel_beat_t  pixels_payload,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  tpd_pkg::cfg_beat_t    cfg_payload,
    output int                    fail_count,
    output int                    pending
);

    // shadow configuration
    logic        rle_on;
    logic [1:0]  depth_sel;
    logic [15:0] img_w;
    logic [15:0] img_h;

    // shadow stream state
    logic [31:0] img_done;
    logic [7:0]  run_left;
    logic        run_is_repeat;
    logic [1:0]  byte_pos;
    logic [7:0]  held_bytes [0:2];

    tpd_pkg::pixel_beat_t want_q [$];
    int                   n_fail = 0;

    assign fail_count = n_fail;

    task automatic restart_image();
        img_done      = '0;
        run_left      = '0;
        run_is_repeat = 1'b0;
        byte_pos      = '0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    task automatic apply_cfg(input tpd_pkg::cfg_beat_t wr);
        bit hit;
        hit = 1'b1;
        case (wr.index)
            tpd_pkg::REG_RLE_MODE:     rle_on    = wr.value[0];
            tpd_pkg::REG_DEPTH_SELECT: depth_sel = wr.value[1:0];
            tpd_pkg::REG_IMAGE_WIDTH:  img_w     = wr.value;
            tpd_pkg::REG_IMAGE_HEIGHT: img_h     = wr.value;
            default:                   hit       = 1'b0;
        endcase
        if (hit)
            restart_image();
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [2:0]           bpp;
        logic                 rle;
        logic [15:0]          w;
        logic [15:0]          h;
        logic [31:0]          total;
        logic [31:0]          remaining;
        logic [31:0]          count;
        logic [15:0]          word;
        tpd_pkg::pixel_beat_t px;
        bpp = (depth_sel == tpd_pkg::DEPTH_16) ? 3'd2
            : (depth_sel == tpd_pkg::DEPTH_24) ? 3'd3 : 3'd4;
        rle = rle_on && (depth_sel != tpd_pkg::DEPTH_16);
        w = (img_w == '0) ? 16'd1 : img_w;
        h = (img_h == '0) ? 16'd1 : img_h;
        total = {16'd0, w} * {16'd0, h};
        if (img_done >= total)
            restart_image();
        remaining = total - img_done;

        if (rle && run_left == '0)
        begin
            // packet header: no pixel out
            if (b < tpd_pkg::RLE_REPEAT_FLAG)
            begin
                run_left      = b + 8'd1;
                run_is_repeat = 1'b0;
            end
            else
            begin
                run_left      = b - (tpd_pkg::RLE_REPEAT_FLAG - 8'd1);
                run_is_repeat = 1'b1;
            end
        end
        else if (({1'b0, byte_pos} + 3'd1) < bpp)
        begin
            held_bytes[byte_pos] = b;
            byte_pos             = byte_pos + 2'd1;
        end
        else
        begin
            byte_pos = '0;
            px.alpha = '0;
            if (bpp == 3'd2)
            begin
                word     = {b, held_bytes[0]};
                px.blue  = {word[4:0], 3'b000};
                px.green = {word[9:5], 3'b000};
                px.red   = {word[14:10], 3'b000};
            end
            else
            begin
                px.blue  = held_bytes[0];
                px.green = held_bytes[1];
                if (bpp == 3'd3)
                    px.red = b;
                else
                begin
                    px.red   = held_bytes[2];
                    px.alpha = b;
                end
            end

            if (rle && run_is_repeat)
            begin
                // clip the run at the end of the image
                count    = ({24'd0, run_left} < remaining) ? {24'd0, run_left} : remaining;
                run_left = '0;
            end
            else
            begin
                count = 32'd1;
                if (rle)
                    run_left = run_left - 8'd1;
            end

            img_done        = img_done + count;
            px.repeat_count = count[7:0];
            px.last_pixel   = (img_done >= total);
            want_q.push_back(px);
            if (px.last_pixel)
                restart_image();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_on    = 1'b0;
            depth_sel = tpd_pkg::DEPTH_24;
            img_w     = 16'd1;
            img_h     = 16'd1;
            restart_image();
            want_q.delete();
            pending <= 0;
        end
        else
        begin
            // a pixel beat leaving now comes from an earlier byte: compare first
            if (pixels_valid && pixels_ready)
            begin
                if (want_q.size() == 0)
                begin
                    $error("pixel beat with no pending expectation");
                    n_fail++;
                end
                else
                begin
                    tpd_pkg::pixel_beat_t want;
                    want = want_q.pop_front();
                    check_field("red", 32'(want.red), 32'(pixels_payload.red));
                    check_field("green", 32'(want.green), 32'(pixels_payload.green));
                    check_field("blue", 32'(want.blue), 32'(pixels_payload.blue));
                    check_field("alpha", 32'(want.alpha), 32'(pixels_payload.alpha));
                    check_field("repeat_count", 32'(want.repeat_count),
                                32'(pixels_payload.repeat_count));
                    check_field("last_pixel", 32'(want.last_pixel),
                                32'(pixels_payload.last_pixel));
                end
            end
            if (cfg_valid && cfg_ready)
                apply_cfg(cfg_payload);
            if (stream_valid && stream_ready)
                decode_byte(stream_payload.data_byte);
            pending <= want_q.size();
        end
    end

endmodule

>>> tb/tb_tga_pixel_stream_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tga_pixel_stream_decoder_top
// Drives image pixel bytes and config writes into the decoder, stalls the
// pixel output at random and leaves prediction and comparison to the
// checker beside the block; gives the verdict at the end.
// ----------------------------------------------------------------------------
module tb_tga_pixel_stream_decoder_top;

    // the depth code with no name in the package; decodes as 32 bpp
    localparam logic [1:0]                    DEPTH_SPARE = 2'd3;
    // an index past the four registers: must be ignored
    localparam logic [tpd_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 4'd15;

    localparam int RANDOM_BYTES   = 700;
    localparam int MAX_GAP        = 11;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 4;     // one stage of logic, plus margin
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 3000;  // well past the hold and any gap

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tpd_stream_if #(.payload_t(tpd_pkg::byte_beat_t))  stream_ch ();
    tpd_stream_if #(.payload_t(tpd_pkg::pixel_beat_t)) pixel_ch ();
    tpd_stream_if #(.payload_t(tpd_pkg::cfg_beat_t))   cfg_ch ();

    tga_pixel_stream_decoder_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .pixels (pixel_ch),
        .cfg    (cfg_ch)
    );

    int fail_count;
    int pending;

    tpd_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .stream_valid   (stream_ch.valid),
        .stream_ready   (stream_ch.ready),
        .stream_payload (stream_ch.payload),
        .pixels_valid   (pixel_ch.valid),
        .pixels_ready   (pixel_ch.ready),
        .pixels_payload (pixel_ch.payload),
        .cfg_valid      (cfg_ch.valid),
        .cfg_ready      (cfg_ch.ready),
        .cfg_payload    (cfg_ch.payload),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // shared between the stimulus side and the pixel sink
    bit no_idle       = 1'b0;   // both sides run without gaps
    bit long_hold_req = 1'b0;   // sink takes one long hold-off when it sees this
    int bytes_sent    = 0;

    // stimulus side's copy of the mode, to shape well-formed packets
    logic       rle_cur   = 1'b0;
    logic [1:0] depth_cur = tpd_pkg::DEPTH_24;

    // ------------------------------------------------------------------
    // Watchdog: any cycle with no beat on any channel counts toward the
    // limit; a beat anywhere clears it.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((stream_ch.valid && stream_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte source helpers. valid stays high from one beat to the next when
    // no gap is drawn, so it is never lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid             <= 1'b1;
        stream_ch.payload.data_byte <= b;
        @(posedge clk);
        while (!stream_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_pixel(input int n_bytes);
        repeat (n_bytes) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Stop offering bytes and wait until every predicted pixel is out.
    // Header and partial-pixel bytes give nothing to wait on, so let the
    // single decode stage settle before anything else happens.
    task automatic drain();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // config beats back to back keep valid high; only the last lowers it
    task automatic cfg_write(input logic [tpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val, input bit last);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.payload.index <= idx;
        cfg_ch.payload.value <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (last)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input logic rle, input logic [1:0] depth,
                              input logic [15:0] w, input logic [15:0] h);
        drain();
        cfg_write(tpd_pkg::REG_RLE_MODE, {15'd0, rle}, 1'b0);
        cfg_write(tpd_pkg::REG_DEPTH_SELECT, {14'd0, depth}, 1'b0);
        cfg_write(tpd_pkg::REG_IMAGE_WIDTH, w, 1'b0);
        cfg_write(tpd_pkg::REG_IMAGE_HEIGHT, h, 1'b1);
        rle_cur   = rle;
        depth_cur = depth;
    endtask

    // ------------------------------------------------------------------
    // Pixel sink: a random stall per beat, a long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        pixel_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall         = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                pixel_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixel_ch.ready <= 1'b1;
            @(posedge clk);
            while (!pixel_ch.valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed cases, random phases, verdict.
    // ------------------------------------------------------------------
    initial
    begin
        int         phase;
        int         units;
        int         pix_len;
        int         npix;
        int         rand_start;
        logic       rle;
        logic [1:0] depth;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0] hdr;
        bit         rle_eff;

        rst_n                <= 1'b0;
        stream_ch.valid      <= 1'b0;
        stream_ch.payload    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.payload       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: raw, 24 bpp, one pixel; B,G,R in -> R,G,B out
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);

        // 16 bpp 1-5-5-5: all-ones and all-zeros words
        set_config(1'b0, tpd_pkg::DEPTH_16, 16'd2, 16'd1);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);

        // 32 bpp run-length: a repeat of two, then the longest repeat,
        // which gets clipped to the one pixel left
        set_config(1'b1, tpd_pkg::DEPTH_32, 16'd3, 16'd1);
        send_byte(8'h81);
        send_pixel(4);
        send_byte(8'hFF);
        send_pixel(4);

        // raw packet running past the end: the packet ends with the image,
        // so the next byte is a header again
        set_config(1'b1, tpd_pkg::DEPTH_24, 16'd1, 16'd1);
        send_byte(8'h01);
        send_pixel(3);
        send_byte(8'h00);
        send_pixel(3);

        // spare depth code acts as 32 bpp; zero height is taken as one row;
        // a write to an unused index must not restart the image
        set_config(1'b0, DEPTH_SPARE, 16'd2, 16'd0);
        send_pixel(4);
        drain();
        cfg_write(REG_UNUSED, 16'hFFFF, 1'b1);
        send_pixel(4);

        // run-length at 16 bpp falls back to raw; zero width and height
        set_config(1'b1, tpd_pkg::DEPTH_16, 16'd0, 16'd0);
        send_pixel(2);

        // random phases: a fresh config each, mostly small images so that
        // image ends come often, now and then the largest sizes
        rand_start = bytes_sent;
        phase      = 0;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            if (phase == 0)
            begin
                rle = 1'b1; depth = tpd_pkg::DEPTH_32; w = 16'hFFFF; h = 16'hFFFF;
            end
            else if (phase == 1)
            begin
                rle = 1'b0; depth = tpd_pkg::DEPTH_16; w = 16'hFFFF; h = 16'd1;
            end
            else
            begin
                rle   = 1'($urandom_range(0, 1));
                depth = 2'($urandom_range(0, 3));
                w = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(1, 6));
                h = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 3));
            end
            set_config(rle, depth, w, h);

            // phase two floods the input while the sink holds off
            no_idle = (phase == 2) || ($urandom_range(0, 3) == 0);
            if (phase == 2)
                long_hold_req = 1'b1;

            pix_len = (depth_cur == tpd_pkg::DEPTH_16) ? 2
                    : (depth_cur == tpd_pkg::DEPTH_24) ? 3 : 4;
            rle_eff = rle_cur && (depth_cur != tpd_pkg::DEPTH_16);
            units   = $urandom_range(4, 16);
            repeat (units)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    if (rle_eff)
                    begin
                        // well-formed packet: mostly short raw or any repeat
                        if ($urandom_range(0, 1))
                            hdr = 8'($urandom_range(128, 255));
                        else if ($urandom_range(0, 7) == 0)
                            hdr = 8'($urandom_range(0, 127));
                        else
                            hdr = 8'($urandom_range(0, 4));
                        send_byte(hdr);
                        // long raw packets are cut short: the rest arrives
                        // as whatever bytes follow
                        if (hdr >= tpd_pkg::RLE_REPEAT_FLAG)
                            npix = 1;
                        else if (hdr < 8'd8)
                            npix = hdr + 1;
                        else
                            npix = $urandom_range(1, 4);
                        repeat (npix) send_pixel(pix_len);
                    end
                    else
                        send_pixel(pix_len);
                end
                else
                begin
                    // noise: stray bytes that shift the framing
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
                end
            end
            phase++;
        end

        // all bytes in: wait out every predicted pixel, then a short tail
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> tga_pixel_stream_decoder_top.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_stream_if.sv
hw/rtl/tga_pixel_stream_decoder_top.sv
tb/tpd_pixel_checker.sv
tb/tb_tga_pixel_stream_decoder_top.sv
